// ----- rtl/cray64_float_multiply_assert.svh -----
// Assertion macros for the float multiply pipeline
`ifndef CRAY64_FLOAT_MULTIPLY_ASSERT_SVH
`define CRAY64_FLOAT_MULTIPLY_ASSERT_SVH

// clocked implication, disabled during reset
`define CFM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define CFM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/cfm_pkg.sv -----
`default_nettype none
package cfm_pkg;
    localparam int COEFF_WIDTH = 48;
    localparam int GUARD_BITS  = 7;
    localparam int ACC_BITS    = COEFF_WIDTH + GUARD_BITS + 1;
    localparam int EXPO_WIDTH  = 15;
    localparam int LEAVES      = 64;
    localparam int LEVELS      = 6;

    localparam logic [16:0] EXPO_BIAS = 17'o040000;
    localparam logic [16:0] EXPO_MIN1 = 17'o017777;
    localparam logic [16:0] EXPO_MAX  = 17'o057777;
    localparam logic [EXPO_WIDTH-1:0] EXPO_OVF = 15'o060000;

    localparam logic [1:0] OP_ROUNDED   = 2'd0;
    localparam logic [1:0] OP_UNROUNDED = 2'd1;
    localparam logic [1:0] OP_RECIP     = 2'd2;

    typedef struct packed {
        logic                  recip;
        logic                  sign;
        logic                  both_zero;
        logic                  underflow;
        logic                  overflow;
        logic [EXPO_WIDTH-1:0] expo;
    } side_t;

    function automatic logic [ACC_BITS-1:0] acc_start(input logic [1:0] op);
        logic [ACC_BITS-1:0] r;
        case (op)
            OP_UNROUNDED: r = ACC_BITS'('o011);
            OP_RECIP:     r = ACC_BITS'(0) - ACC_BITS'(199);
            default:      r = ACC_BITS'('o151);
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/cray64_float_multiply.sv -----
// Floating-point multiply, 64-bit format (sign, 15-bit biased exponent,
// 48-bit coefficient), one result item for each operand item.
// Input: s_tvalid/s_tready/s_tdata carry the two operands; s_tuser carries
// the op (0 rounded, 1 unrounded, 2 reciprocal iteration, 3 as rounded).
// Output: m_tvalid/m_tready/m_tdata carry product and status flags.
// Throughput: one item per cycle while the receiver does not stall. A result
// passes from acceptance to m_tvalid through the input register, a six-level registered adder tree
// over the 48 partial products plus start constant, and the output stage.
// Reset (aresetn low, synchronous) clears all valid bits; the pipe is empty.
// When the receiver stalls with a result waiting, the whole pipe holds and
// s_tready drops; nothing is lost or repeated.
`default_nettype none
`include "cray64_float_multiply_assert.svh"
module cray64_float_multiply (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // a_sign, a_expo[14:0], a_coeff[47:0], b_sign, b_expo[14:0], b_coeff[47:0]
    input  wire logic [127:0] s_tdata,
    // op[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // prod_sign, prod_expo[14:0], prod_coeff[47:0], underflow, overflow,
    // is_zero, negative, zero pad
    output logic [71:0]       m_tdata
);
    localparam int CW = cfm_pkg::COEFF_WIDTH;
    localparam int AW = cfm_pkg::ACC_BITS;
    localparam int NL = cfm_pkg::LEVELS;

    logic en;
    logic [NL+1:0] vld_reg;
    cfm_pkg::side_t side_reg [0:NL];
    cfm_pkg::side_t side_next;
    logic [CW-1:0] ac_reg, bc_reg;
    logic [AW-1:0] start_reg;
    logic [AW-1:0] tree_reg [1:NL][0:cfm_pkg::LEAVES/2-1];
    logic [AW-1:0] leaf [0:cfm_pkg::LEAVES-1];
    logic [71:0] out_reg, out_next;

    logic [14:0] ae, be;
    logic [16:0] xe;

    assign en       = !vld_reg[NL+1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NL+1];
    assign m_tdata  = out_reg;

    assign ae = s_tdata[15:1];
    assign be = s_tdata[79:65];
    assign xe = 17'(ae) + 17'(be) - cfm_pkg::EXPO_BIAS;

    always_comb begin
        side_next.recip     = (s_tuser == cfm_pkg::OP_RECIP);
        side_next.both_zero = (ae == '0) && (be == '0);
        side_next.sign      = (s_tdata[0] ^ s_tdata[64]) && !side_next.both_zero;
        side_next.underflow = !side_next.both_zero &&
            (17'(ae) < cfm_pkg::EXPO_MIN1 || 17'(be) < cfm_pkg::EXPO_MIN1 ||
             $signed(xe) < $signed(cfm_pkg::EXPO_MIN1));
        side_next.overflow  = (!side_next.both_zero &&
            $signed(xe) >= $signed(cfm_pkg::EXPO_MAX)) ||
            17'(ae) > cfm_pkg::EXPO_MAX || 17'(be) > cfm_pkg::EXPO_MAX;
        side_next.expo      = side_next.both_zero ? '0 : xe[14:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NL:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ac_reg      <= s_tdata[63:16];
            bc_reg      <= s_tdata[127:80];
            start_reg   <= cfm_pkg::acc_start(s_tuser);
            side_reg[0] <= side_next;
            for (int k = 1; k <= NL; k++) side_reg[k] <= side_reg[k-1];
            out_reg     <= out_next;
        end
    end

    always_comb begin
        for (int i = 0; i < cfm_pkg::LEAVES; i++) begin
            if (i < CW)
                leaf[i] = bc_reg[CW-1-i] ? (AW'(ac_reg) << cfm_pkg::GUARD_BITS) >> i : '0;
            else if (i == CW)
                leaf[i] = start_reg;
            else
                leaf[i] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < cfm_pkg::LEAVES/2; i++)
                tree_reg[1][i] <= leaf[2*i] + leaf[2*i+1];
            for (int l = 2; l <= NL; l++)
                for (int i = 0; i < (cfm_pkg::LEAVES >> l); i++)
                    tree_reg[l][i] <= tree_reg[l-1][2*i] + tree_reg[l-1][2*i+1];
        end
    end

    always_comb begin
        cfm_pkg::side_t s;
        logic [AW-1:0] acc;
        logic top;
        logic [CW-1:0] coeff;
        logic [14:0] expo;
        logic zero;
        s   = side_reg[NL];
        acc = tree_reg[NL][0];
        if (s.recip) acc = acc ^ {1'b1, {CW{1'b1}}, {cfm_pkg::GUARD_BITS{1'b0}}};
        top   = acc[AW-1];
        coeff = acc[AW-2:cfm_pkg::GUARD_BITS];
        expo  = s.expo;
        if (top || s.both_zero) begin
            coeff = {top, coeff[CW-1:1]};
            if (!s.both_zero) expo = expo + 15'd1;
        end
        if (s.overflow) expo = cfm_pkg::EXPO_OVF;
        zero = !s.sign && expo == '0 && coeff == '0;
        if (s.underflow)
            out_next = {4'd0, 1'b0, 1'b1, 1'b0, 1'b1, 48'd0, 15'd0, 1'b0};
        else
            out_next = {4'd0, s.sign, zero, s.overflow, 1'b0, coeff, expo, s.sign};
    end

    `CFM_ASSERT_IMP(a_uf_zero, aclk, aresetn, m_tvalid && m_tdata[64], m_tdata[66] && m_tdata[63:0] == '0)
    `CFM_ASSERT_IMP(a_ovf_expo, aclk, aresetn, m_tvalid && m_tdata[65], m_tdata[15:1] == cfm_pkg::EXPO_OVF)
    `CFM_ASSERT_IMP(a_stall_block, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    `CFM_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule
`default_nettype wire
